### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(name, cond, msg) \
  `ASSERT_CLK(name, !(cond), msg)

`endif

### hw/rtl/pmst_pkg.sv
package pmst_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = VW + 1;
  localparam int unsigned EW = 2 * VW;
  localparam int unsigned EDGES = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned WW = 16;
  localparam int unsigned TW = 22;
  localparam logic signed [WW-1:0] ONE_Q8_8 = 16'sd256;

  typedef enum logic [1:0] {
    KIND_ADD_VERTEX = 2'd0,
    KIND_ADD_EDGE   = 2'd1,
    KIND_RUN        = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_TREE_EDGE    = 3'd0,
    ST_CONNECTED    = 3'd1,
    ST_DISCONNECTED = 3'd2,
    ST_NOT_WEIGHTED = 3'd3,
    ST_EMPTY        = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_DIRECTED = 1'b0,
    CFG_WEIGHTED = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_REV,
    S_FIND,
    S_RELAX,
    S_PICK,
    S_DECIDE,
    S_FINAL
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic add_vertex;
    logic add_edge;
    logic wr_rev;
    logic load_err;
    logic start_run;
    logic scan_clr;
    logic find_step;
    logic relax_step;
    logic pick_step;
    logic commit;
    logic load_final;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic directed;
    logic err;
    logic find_hit;
    logic scan_done;
    logic pick_found;
    logic n_full;
    logic out_free;
  } stat_t;

endpackage

### hw/rtl/pmst_ctrl.sv
module pmst_ctrl import pmst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] kind_i,
  output logic       in_ready_o,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (stat_i.clear_last) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_ADD_EDGE && !stat_i.directed) state_d = S_WR_REV;
          if (kind_i == KIND_RUN && !stat_i.err) state_d = S_FIND;
        end
      end
      S_WR_REV: state_d = S_IDLE;
      S_FIND:   if (stat_i.find_hit) state_d = S_RELAX;
      S_RELAX:  if (stat_i.scan_done) state_d = S_PICK;
      S_PICK:   if (stat_i.scan_done) state_d = S_DECIDE;
      S_DECIDE: begin
        if (!stat_i.pick_found || stat_i.n_full) state_d = S_FINAL;
        else if (stat_i.out_free) state_d = S_RELAX;
      end
      S_FINAL:  if (stat_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_CLEAR: cmd_o.clr_step = 1'b1;
      S_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_ADD_VERTEX: cmd_o.add_vertex = 1'b1;
            KIND_ADD_EDGE:   cmd_o.add_edge = 1'b1;
            KIND_RUN: begin
              if (stat_i.err) begin
                cmd_o.load_err = 1'b1;
              end else begin
                cmd_o.start_run = 1'b1;
                cmd_o.scan_clr  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_WR_REV: cmd_o.wr_rev = 1'b1;
      S_FIND: begin
        cmd_o.find_step = 1'b1;
        cmd_o.scan_clr  = stat_i.find_hit;
      end
      S_RELAX: begin
        cmd_o.relax_step = 1'b1;
        cmd_o.scan_clr   = stat_i.scan_done;
      end
      S_PICK: cmd_o.pick_step = 1'b1;
      S_DECIDE: begin
        if (stat_i.pick_found && !stat_i.n_full && stat_i.out_free) begin
          cmd_o.commit   = 1'b1;
          cmd_o.scan_clr = 1'b1;
        end
      end
      S_FINAL: cmd_o.load_final = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

### hw/rtl/pmst_datapath.sv
module pmst_datapath import pmst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic                 cfg_data_i,
  input  logic [VW-1:0]        from_vertex_i,
  input  logic [VW-1:0]        to_vertex_i,
  input  logic signed [WW-1:0] weight_i,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [2:0]           status_o,
  output logic [VW-1:0]        edge_from_o,
  output logic [VW-1:0]        edge_to_o,
  output logic signed [WW-1:0] edge_weight_o,
  output logic signed [TW-1:0] total_cost_o,
  output logic                 last_o
);

  // config
  logic directed_q, weighted_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      directed_q <= 1'b0;
      weighted_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DIRECTED: directed_q <= cfg_data_i;
        CFG_WEIGHTED: weighted_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // vertex flags
  logic [MAX_VERTICES-1:0] present_q, visited_q, kv_q;
  logic [CW-1:0]           count_q;
  logic [EW-1:0]           clr_q;

  // scan pipeline
  logic [CW-1:0] scan_q;
  logic [VW-1:0] scan_idx, p_v_q, u_q;
  logic          p_vld_q, p_relax_q, scan_end, issue;

  // edge and key stores, {valid, weight} and {parent, weight}
  logic [WW:0]         edge_mem [EDGES];
  logic [VW+WW-1:0]    key_mem [MAX_VERTICES];
  logic [WW:0]         edge_rd_q;
  logic [VW+WW-1:0]    key_rd_q;
  logic                em_we, km_we;
  logic [EW-1:0]       em_waddr;
  logic [WW:0]         em_wdata;
  logic signed [WW-1:0] w_eff, ew, kw;

  // latched edge for the reverse write
  logic [VW-1:0]        a_q, b_q;
  logic signed [WW-1:0] w_q;

  // pick tracking
  logic                 found_q;
  logic [VW-1:0]        pick_v_q, pick_par_q;
  logic signed [WW-1:0] pick_w_q;
  logic [CW-1:0]        n_q;
  logic signed [TW-1:0] total_q;

  logic upd, elig, better, out_valid_q;

  assign scan_idx = scan_q[VW-1:0];
  assign scan_end = (scan_q == CW'(MAX_VERTICES));
  assign issue    = (cmd_i.relax_step || cmd_i.pick_step) && !scan_end;
  assign w_eff    = weighted_q ? weight_i : ONE_Q8_8;
  assign ew       = edge_rd_q[WW-1:0];
  assign kw       = key_rd_q[WW-1:0];

  assign em_we    = cmd_i.clr_step || cmd_i.add_edge || cmd_i.wr_rev;
  always_comb begin
    if (cmd_i.clr_step) begin
      em_waddr = clr_q;
      em_wdata = '0;
    end else if (cmd_i.wr_rev) begin
      em_waddr = {b_q, a_q};
      em_wdata = {1'b1, w_q};
    end else begin
      em_waddr = {from_vertex_i, to_vertex_i};
      em_wdata = {1'b1, w_eff};
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_we) edge_mem[em_waddr] <= em_wdata;
    edge_rd_q <= edge_mem[{u_q, scan_idx}];
  end

  assign upd = p_vld_q && p_relax_q && present_q[p_v_q] && !visited_q[p_v_q]
               && edge_rd_q[WW] && (!kv_q[p_v_q] || (ew < kw));
  assign km_we = upd;

  always_ff @(posedge clk_i) begin
    if (km_we) key_mem[p_v_q] <= {u_q, ew};
    key_rd_q <= key_mem[scan_idx];
  end

  assign elig   = p_vld_q && !p_relax_q && present_q[p_v_q] && !visited_q[p_v_q]
                  && kv_q[p_v_q];
  assign better = !found_q || (kw < pick_w_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_edge) begin
      a_q <= from_vertex_i;
      b_q <= to_vertex_i;
      w_q <= w_eff;
    end
    if (elig && better) begin
      pick_v_q   <= p_v_q;
      pick_w_q   <= kw;
      pick_par_q <= key_rd_q[VW+WW-1:WW];
    end
    if (cmd_i.find_step && stat_o.find_hit) u_q <= scan_idx;
    else if (cmd_i.commit) u_q <= pick_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      present_q <= '0;
      visited_q <= '0;
      kv_q      <= '0;
      count_q   <= '0;
      scan_q    <= '0;
      p_vld_q   <= 1'b0;
      p_relax_q <= 1'b0;
      p_v_q     <= '0;
      found_q   <= 1'b0;
      n_q       <= '0;
      total_q   <= '0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.add_vertex) begin
        present_q[from_vertex_i] <= 1'b1;
        count_q <= count_q + CW'(!present_q[from_vertex_i]);
      end
      if (cmd_i.add_edge) begin
        present_q[from_vertex_i] <= 1'b1;
        present_q[to_vertex_i]   <= 1'b1;
        count_q <= count_q + CW'(!present_q[from_vertex_i])
                   + CW'(!present_q[to_vertex_i] && (to_vertex_i != from_vertex_i));
      end
      if (cmd_i.start_run) begin
        visited_q <= '0;
        kv_q      <= '0;
        n_q       <= '0;
        total_q   <= '0;
      end
      if (cmd_i.find_step && stat_o.find_hit) visited_q[scan_idx] <= 1'b1;
      if (upd) kv_q[p_v_q] <= 1'b1;
      if (elig && better) found_q <= 1'b1;
      if (cmd_i.commit) begin
        visited_q[pick_v_q] <= 1'b1;
        n_q     <= n_q + 1'b1;
        total_q <= total_q + TW'(pick_w_q);
      end
      if (cmd_i.scan_clr) begin
        scan_q  <= '0;
        p_vld_q <= 1'b0;
        found_q <= 1'b0;
      end else begin
        p_vld_q <= issue;
        if (issue) begin
          scan_q    <= scan_q + 1'b1;
          p_v_q     <= scan_idx;
          p_relax_q <= cmd_i.relax_step;
        end else if (cmd_i.find_step) begin
          scan_q <= scan_q + 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_err || cmd_i.commit || cmd_i.load_final) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_err) begin
      status_o      <= weighted_q ? ST_EMPTY : ST_NOT_WEIGHTED;
      edge_from_o   <= '0;
      edge_to_o     <= '0;
      edge_weight_o <= '0;
      total_cost_o  <= '0;
      last_o        <= 1'b1;
    end else if (cmd_i.commit) begin
      status_o      <= ST_TREE_EDGE;
      edge_from_o   <= pick_par_q;
      edge_to_o     <= pick_v_q;
      edge_weight_o <= pick_w_q;
      total_cost_o  <= '0;
      last_o        <= 1'b0;
    end else if (cmd_i.load_final) begin
      status_o      <= ((CW+1)'(n_q) + 1'b1 < (CW+1)'(count_q)) ? ST_DISCONNECTED
                                                                 : ST_CONNECTED;
      edge_from_o   <= '0;
      edge_to_o     <= '0;
      edge_weight_o <= '0;
      total_cost_o  <= total_q;
      last_o        <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.clear_last = (clr_q == {EW{1'b1}});
  assign stat_o.directed   = directed_q;
  assign stat_o.err        = !weighted_q || (count_q == '0);
  assign stat_o.find_hit   = !scan_end && present_q[scan_idx];
  assign stat_o.scan_done  = scan_end && !p_vld_q;
  assign stat_o.pick_found = found_q;
  assign stat_o.n_full     = (n_q == CW'(MAX_VERTICES - 1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

### hw/rtl/prim_minimum_spanning_tree.sv
// Prim spanning tree engine. An undirected add-edge item also writes the
// mirrored entry before the next input is taken. A run finds the start vertex,
// then each tree step is a relax pass and a pick pass over the 64 slots and a
// decide. Result register: one transaction per cycle out while out_ready_i is
// high. Reset is asynchronous, active low; afterwards a clearing pass sweeps the
// edge store, with no input accepted (config writes still taken).
module prim_minimum_spanning_tree import pmst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic                 cfg_data_i,
  // input transactions
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           kind_i,
  input  logic [VW-1:0]        from_vertex_i,
  input  logic [VW-1:0]        to_vertex_i,
  input  logic signed [WW-1:0] weight_i,
  // result transactions
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [VW-1:0]        edge_from_o,
  output logic [VW-1:0]        edge_to_o,
  output logic signed [WW-1:0] edge_weight_o,
  output logic signed [TW-1:0] total_cost_o,
  output logic                 last_o
);

  // The controller sequences clear, load and run phases; the datapath holds
  // the graph store, key store, scan pipeline and the result register.
  cmd_t  cmd;
  stat_t stat;

  pmst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pmst_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .from_vertex_i (from_vertex_i),
    .to_vertex_i   (to_vertex_i),
    .weight_i      (weight_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .edge_from_o   (edge_from_o),
    .edge_to_o     (edge_to_o),
    .edge_weight_o (edge_weight_o),
    .total_cost_o  (total_cost_o),
    .last_o        (last_o)
  );

endmodule

### hw/rtl/pmst_checker.sv
`include "assert_macros.svh"

module pmst_checker import pmst_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic                 cfg_index_i,
  input logic                 cfg_data_i,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [1:0]           kind_i,
  input logic [VW-1:0]        from_vertex_i,
  input logic [VW-1:0]        to_vertex_i,
  input logic signed [WW-1:0] weight_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [2:0]           status_o,
  input logic [VW-1:0]        edge_from_o,
  input logic [VW-1:0]        edge_to_o,
  input logic signed [WW-1:0] edge_weight_o,
  input logic signed [TW-1:0] total_cost_o,
  input logic                 last_o
);

  `ASSERT_CLK(out_hold_a, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(total_cost_o) && $stable(edge_to_o), "result changed while stalled")
  `ASSERT_NEVER(edge_not_last_a, out_valid_o && !last_o && status_o != ST_TREE_EDGE, "non-edge result without last")
  `ASSERT_CLK(last_zero_edge_a, out_valid_o && last_o |-> edge_from_o == '0 && edge_to_o == '0 && edge_weight_o == '0, "final item carries edge data")
  `ASSERT_CLK(edge_no_total_a, out_valid_o && status_o == ST_TREE_EDGE |-> total_cost_o == '0 && !last_o, "tree edge carries total")

endmodule

bind prim_minimum_spanning_tree pmst_checker u_pmst_checker (.*);

### verif/prim_minimum_spanning_tree_test.sv
module prim_minimum_spanning_tree_test;
  import pmst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // kind code the block must drop without any effect
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned N_ITEMS = 140;

  typedef struct {
    status_e               status;
    logic [VW-1:0]         from_v;
    logic [VW-1:0]         to_v;
    logic signed [WW-1:0]  weight;
    logic signed [TW-1:0]  total;
    logic                  last;
  } tree_result_t;

  // Shadow of the graph store plus a Prim predictor. note_item() is fed
  // every accepted input transaction; check_result() every accepted output.
  class mst_scoreboard;
    bit                   directed_q;
    bit                   weighted_q;
    bit                   present[MAX_VERTICES];
    bit                   edge_on[MAX_VERTICES][MAX_VERTICES];
    logic signed [WW-1:0] edge_w[MAX_VERTICES][MAX_VERTICES];
    int unsigned          n_vertices;
    tree_result_t         expect_q[$];
    int unsigned          n_errors;

    function new();
      directed_q = 1'b0;
      weighted_q = 1'b1;
      n_vertices = 0;
      n_errors   = 0;
      foreach (present[v]) present[v] = 1'b0;
      foreach (edge_on[a, b]) edge_on[a][b] = 1'b0;
    endfunction

    function void write_reg(cfg_idx_e idx, bit val);
      if (idx == CFG_DIRECTED) directed_q = val;
      else weighted_q = val;
    endfunction

    function void mark(int v);
      if (!present[v]) begin
        present[v] = 1'b1;
        n_vertices++;
      end
    endfunction

    function void push(status_e st, int f, int t, logic signed [WW-1:0] w,
                       logic signed [TW-1:0] tot, bit lst);
      tree_result_t r;
      r.status = st;
      r.from_v = f[VW-1:0];
      r.to_v   = t[VW-1:0];
      r.weight = w;
      r.total  = tot;
      r.last   = lst;
      expect_q.insert(expect_q.size(), r);
    endfunction

    function void grow_tree();
      bit                   seen[MAX_VERTICES];
      bit                   has_key[MAX_VERTICES];
      logic signed [WW-1:0] key[MAX_VERTICES];
      int                   parent[MAX_VERTICES];
      int                   root, pick, u, joined;
      logic signed [TW-1:0] sum;
      if (!weighted_q) begin
        push(ST_NOT_WEIGHTED, 0, 0, '0, '0, 1'b1);
        return;
      end
      root = -1;
      for (int v = 0; v < MAX_VERTICES; v++)
        if (root < 0 && present[v]) root = v;
      if (n_vertices == 0 || root < 0) begin
        push(ST_EMPTY, 0, 0, '0, '0, 1'b1);
        return;
      end
      foreach (seen[v]) begin
        seen[v] = 1'b0;
        has_key[v] = 1'b0;
        key[v] = '0;
        parent[v] = 0;
      end
      sum = '0;
      joined = 0;
      u = root;
      seen[u] = 1'b1;
      forever begin
        // relax edges leaving the newest tree vertex; strict < keeps first source
        for (int v = 0; v < MAX_VERTICES; v++) begin
          if (present[v] && !seen[v] && edge_on[u][v] &&
              (!has_key[v] || edge_w[u][v] < key[v])) begin
            has_key[v] = 1'b1;
            key[v] = edge_w[u][v];
            parent[v] = u;
          end
        end
        // cheapest key, lowest index wins ties
        pick = -1;
        for (int v = 0; v < MAX_VERTICES; v++)
          if (present[v] && !seen[v] && has_key[v] && (pick < 0 || key[v] < key[pick]))
            pick = v;
        if (pick < 0 || joined >= 63) break;
        seen[pick] = 1'b1;
        push(ST_TREE_EDGE, parent[pick], pick, key[pick], '0, 1'b0);
        sum += key[pick];
        joined++;
        u = pick;
      end
      push((joined + 1 < n_vertices) ? ST_DISCONNECTED : ST_CONNECTED,
           0, 0, '0, sum, 1'b1);
    endfunction

    function void note_item(logic [1:0] kind, int a, int b, logic signed [WW-1:0] w);
      logic signed [WW-1:0] wv;
      case (kind)
        KIND_ADD_VERTEX: mark(a);
        KIND_ADD_EDGE: begin
          wv = weighted_q ? w : ONE_Q8_8;
          mark(a);
          mark(b);
          edge_on[a][b] = 1'b1;
          edge_w[a][b] = wv;
          if (!directed_q) begin
            edge_on[b][a] = 1'b1;
            edge_w[b][a] = wv;
          end
        end
        KIND_RUN: grow_tree();
        default: ;
      endcase
    endfunction

    function void check_result(logic [2:0] st, logic [VW-1:0] f, logic [VW-1:0] t,
                               logic signed [WW-1:0] w, logic signed [TW-1:0] tot,
                               logic lst);
      tree_result_t e;
      if (expect_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d from=%0d to=%0d", $time, st, f, t);
        n_errors++;
        return;
      end
      e = expect_q.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        n_errors++;
      end
      if (f !== e.from_v) begin
        $display("%0t: edge_from expected %0d actual %0d", $time, e.from_v, f);
        n_errors++;
      end
      if (t !== e.to_v) begin
        $display("%0t: edge_to expected %0d actual %0d", $time, e.to_v, t);
        n_errors++;
      end
      if (w !== e.weight) begin
        $display("%0t: edge_weight expected %0d actual %0d", $time, e.weight, w);
        n_errors++;
      end
      if (tot !== e.total) begin
        $display("%0t: total_cost expected %0d actual %0d", $time, e.total, tot);
        n_errors++;
      end
      if (lst !== e.last) begin
        $display("%0t: last expected %0b actual %0b", $time, e.last, lst);
        n_errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i, cfg_index_i, cfg_data_i;
  logic                 in_valid_i, in_ready_o;
  logic [1:0]           kind_i;
  logic [VW-1:0]        from_vertex_i, to_vertex_i;
  logic signed [WW-1:0] weight_i;
  logic                 out_valid_o, out_ready_i;
  logic [2:0]           status_o;
  logic [VW-1:0]        edge_from_o, edge_to_o;
  logic signed [WW-1:0] edge_weight_o;
  logic signed [TW-1:0] total_cost_o;
  logic                 last_o;

  mst_scoreboard sb = new();
  int unsigned   cycle_cnt = 0;
  int unsigned   results_seen = 0;
  int unsigned   items_sent = 0;
  bit            sender_busy_gaps = 1'b1; // per-phase switch for input gaps
  bit            long_hold_done = 1'b0;

  prim_minimum_spanning_tree uut (.*);

  always #2 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: check on handshake, then pick next ready level.
  // One long hold-off happens once traffic is flowing so the block backs up
  // into its input while the sender keeps offering transactions.
  initial begin
    int hold;
    int quiet;
    hold = 0;
    quiet = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        sb.check_result(status_o, edge_from_o, edge_to_o, edge_weight_o,
                        total_cost_o, last_o);
        results_seen++;
        if (!long_hold_done && results_seen == 25) begin
          long_hold_done = 1'b1;
          hold = 600;
        end
      end
      if (quiet > 0) quiet--;
      else if ($urandom_range(0, 199) == 0) quiet = $urandom_range(50, 300);
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (quiet > 0) begin
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 9) < 3) begin
        // stall: mostly short, sometimes long
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // One register write; the write enable is dropped before the task returns.
  task automatic cfg_write(cfg_idx_e idx, bit val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Offer one transaction; valid stays high across back-to-back items.
  task automatic send(logic [1:0] kind, int a, int b, logic signed [WW-1:0] w);
    int gap;
    gap = 0;
    if (sender_busy_gaps && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    from_vertex_i <= a[VW-1:0];
    to_vertex_i   <= b[VW-1:0];
    weight_i      <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(kind, a, b, w);
    items_sent++;
  endtask

  // Sender pause: let every expected result drain, then settle past the
  // last add (no result of its own) before touching the registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expect_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic signed [WW-1:0] rand_weight();
    case ($urandom_range(0, 3))
      0: return WW'(int'($urandom_range(0, 4)) * 256 - 512); // small values, lots of ties
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return WW'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  initial begin
    int base, a, b, phase_len, r;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= 1'b0;
    cfg_data_i    <= 1'b0;
    in_valid_i    <= 1'b0;
    kind_i        <= KIND_ADD_VERTEX;
    from_vertex_i <= '0;
    to_vertex_i   <= '0;
    weight_i      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part: error ordering, extremes, overwrite, self loop, ties
    cfg_write(CFG_WEIGHTED, 1'b0);
    send(KIND_RUN, 0, 0, '0);             // not weighted wins over empty
    drain();
    cfg_write(CFG_WEIGHTED, 1'b1);
    send(KIND_RUN, 63, 63, '0);           // empty graph
    send(KIND_UNUSED, 5, 6, 16'sh1234);   // dropped
    send(KIND_ADD_VERTEX, 63, 0, '0);
    send(KIND_RUN, 0, 0, '0);             // lone vertex: connected, cost 0
    send(KIND_ADD_EDGE, 0, 63, 16'sh8000);
    send(KIND_ADD_EDGE, 63, 21, 16'sh7fff);
    send(KIND_ADD_EDGE, 42, 42, 16'sh8000); // self loop, never a tree edge
    send(KIND_ADD_EDGE, 0, 21, 16'sh0100);
    send(KIND_ADD_EDGE, 0, 21, 16'sh7fff);  // overwrite both directions
    send(KIND_RUN, 0, 0, '0);             // 42 unreachable: disconnected
    send(KIND_ADD_EDGE, 21, 42, 16'sh0200);
    send(KIND_ADD_EDGE, 63, 42, 16'sh0200); // tie on key for 42
    send(KIND_RUN, 0, 0, '0);
    drain();
    cfg_write(CFG_DIRECTED, 1'b1);
    send(KIND_ADD_EDGE, 42, 10, 16'shff00);
    send(KIND_ADD_EDGE, 10, 0, 16'sh8000);  // one way only, never a tree edge
    send(KIND_ADD_EDGE, 42, 11, 16'shff00); // equal keys, lowest index first
    send(KIND_RUN, 0, 0, '0);
    drain();
    cfg_write(CFG_WEIGHTED, 1'b0);
    send(KIND_ADD_EDGE, 11, 12, 16'sh8000); // stored as 1.0
    drain();
    cfg_write(CFG_WEIGHTED, 1'b1);
    cfg_write(CFG_DIRECTED, 1'b0);
    send(KIND_RUN, 0, 0, '0);

    // random phases: build a cluster of edges, then ask for a tree
    while (items_sent < N_ITEMS) begin
      drain();
      r = $urandom_range(0, 9);
      cfg_write(CFG_DIRECTED, r < 3);
      cfg_write(CFG_WEIGHTED, r != 9);
      sender_busy_gaps = ($urandom_range(0, 3) != 0);
      base = $urandom_range(0, 48);
      phase_len = $urandom_range(5, 14);
      for (int i = 0; i < phase_len; i++) begin
        r = $urandom_range(0, 19);
        a = (r == 0) ? $urandom_range(0, 63) : base + $urandom_range(0, 15);
        b = (r == 1) ? $urandom_range(0, 63) : base + $urandom_range(0, 15);
        if (r < 14)       send(KIND_ADD_EDGE, a, b, rand_weight());
        else if (r < 17)  send(KIND_ADD_VERTEX, a, 0, '0);
        else if (r < 18)  send(KIND_UNUSED, a, b, rand_weight());
        else              send(KIND_RUN, a, b, rand_weight());
      end
      send(KIND_RUN, 0, 0, '0);
    end

    in_valid_i <= 1'b0;
    while (sb.expect_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### prim_minimum_spanning_tree.f
+incdir+hw/rtl
hw/rtl/pmst_pkg.sv
hw/rtl/pmst_ctrl.sv
hw/rtl/pmst_datapath.sv
hw/rtl/prim_minimum_spanning_tree.sv
hw/rtl/pmst_checker.sv
verif/prim_minimum_spanning_tree_test.sv
